// ----- rtl/tt_pkg.sv -----
// ============================================================================
// tt_pkg - shared types and constants for the tap tempo meter
// Widths, reset values, opcodes and the controller/datapath interface.
// ============================================================================
`default_nettype none

package tt_pkg;

    // Field and storage widths
    localparam int COUNT_BITS     = 16;
    localparam int TIME_BITS      = 32;
    localparam int TEMPO_BITS     = 24;
    localparam int DELAY_BITS     = 16;
    localparam int IVL_BITS       = 24;
    localparam int APB_ADDR_BITS  = 3;
    localparam int APB_DATA_BITS  = 32;

    // Tempo scale: hundredths of a beat per minute, in milliseconds
    localparam int SCALE_BITS     = 23;
    localparam int NUM_BITS       = COUNT_BITS + SCALE_BITS;
    localparam int STEP_BITS      = $clog2(NUM_BITS + 1);
    localparam logic [NUM_BITS-1:0] MS_PER_MIN_X100 = NUM_BITS'(6000000);

    // Register reset values
    localparam logic [DELAY_BITS-1:0] AUTO_STOP_RESET    = DELAY_BITS'(2000);
    localparam logic [IVL_BITS-1:0]   LOG_INTERVAL_RESET = IVL_BITS'(15000);

    // Register index (byte address bit 2)
    localparam logic REG_AUTO_STOP = 1'b0;
    localparam logic REG_LOG_IVL   = 1'b1;

    typedef enum logic [1:0] {
        KIND_TAP   = 2'd0,
        KIND_KEY   = 2'd1,
        KIND_TICK  = 2'd2,
        KIND_RESET = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ITEM_STATUS = 2'd0,
        ITEM_LOG    = 2'd1,
        ITEM_GROUP  = 2'd2
    } item_type_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_GROUP,
        ST_TAP,
        ST_TEMPO_DIV,
        ST_TEMPO_WAIT,
        ST_TICK,
        ST_LOG_DIV,
        ST_LOG_WAIT,
        ST_LOG_EMIT,
        ST_STOP_CHECK,
        ST_STOP_GROUP,
        ST_STATUS
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic       load_in;
        logic       clear_run;
        logic       do_tap;
        logic       mark;
        logic       stop_run;
        logic       div_start;
        logic       div_log;
        logic       tempo_load;
        logic       log_update;
        logic       base_adv;
        logic       emit;
        item_type_t emit_type;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        kind_t kind;
        logic  run_active;
        logic  group_nonzero;
        logic  keys_seen;
        logic  log_due;
        logic  stop_due;
        logic  div_done;
        logic  out_free;
    } stat_t;

endpackage

`default_nettype wire

// ----- rtl/tap_tempo_bpm_meter_unit.sv -----
// ============================================================================
// tap_tempo_bpm_meter_unit - tap tempo meter, top level
// Controller, run-state datapath and iterative divider behind an APB port.
// ============================================================================
// Takes one input word at a time (tap, key tap, timer tick or reset) and
// answers with up to four result words, the last being a status word with
// last set. Each tempo figure comes from a shared restoring divider that
// loads the product and then forms the quotient one bit at a time. A stall
// on the result side holds the sequence, and the next word is accepted
// once the status word sits in the output register.
`default_nettype none

module tap_tempo_bpm_meter_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // input words
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [1:0]                        kind,
    input  wire logic [31:0]                       time_ms,
    input  wire logic                              double_tap,
    // result words
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [1:0]                             item_type,
    output logic [23:0]                            bpm_x100,
    output logic [23:0]                            interval_bpm_x100,
    output logic [15:0]                            beat_count,
    output logic [31:0]                            elapsed_ms,
    output logic [15:0]                            group_length,
    output logic                                   running,
    output logic                                   last,
    // config port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [tt_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  wire logic [tt_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [tt_pkg::APB_DATA_BITS-1:0]       prdata,
    output logic                                   pready
);

    tt_pkg::cmd_t                   cmd;
    tt_pkg::stat_t                  stat;
    logic [tt_pkg::COUNT_BITS-1:0]  div_nm1;
    logic [tt_pkg::TIME_BITS-1:0]   div_dt;
    logic                           div_done;
    logic [tt_pkg::TEMPO_BITS-1:0]  div_result;
    logic                           cfg_we;

    // APB write strobe, zero wait states
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    tt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    tt_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.div_start),
        .nm1    (div_nm1),
        .dt     (div_dt),
        .done   (div_done),
        .result (div_result)
    );

    tt_datapath u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .kind              (kind),
        .time_ms           (time_ms),
        .double_tap        (double_tap),
        .cfg_we            (cfg_we),
        .cfg_index         (paddr[2]),
        .cfg_wdata         (pwdata),
        .cfg_rdata         (prdata),
        .div_nm1           (div_nm1),
        .div_dt            (div_dt),
        .div_done          (div_done),
        .div_result        (div_result),
        .out_stall         (out_stall),
        .out_valid         (out_valid),
        .item_type         (item_type),
        .bpm_x100          (bpm_x100),
        .interval_bpm_x100 (interval_bpm_x100),
        .beat_count        (beat_count),
        .elapsed_ms        (elapsed_ms),
        .group_length      (group_length),
        .running           (running),
        .last              (last)
    );

endmodule

`default_nettype wire

// ----- rtl/tt_div.sv -----
// ============================================================================
// tt_div - iterative tempo divider
// Registers (n-1)*6000000, then one restoring quotient bit per cycle.
// Result saturates to the tempo width and is zero for a zero divisor.
// ============================================================================
`default_nettype none

module tt_div (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [tt_pkg::COUNT_BITS-1:0]   nm1,
    input  wire logic [tt_pkg::TIME_BITS-1:0]    dt,
    output logic                                 done,
    output logic [tt_pkg::TEMPO_BITS-1:0]        result
);

    logic [tt_pkg::NUM_BITS-1:0]   quo_reg;
    logic [tt_pkg::TIME_BITS-1:0]  rem_reg;
    logic [tt_pkg::TIME_BITS-1:0]  den_reg;
    logic [tt_pkg::STEP_BITS-1:0]  cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;

    logic [tt_pkg::TIME_BITS:0]    trial;
    logic [tt_pkg::TIME_BITS:0]    diff;
    logic                          ge;

    // One restoring step
    always_comb
    begin
        trial = {rem_reg, quo_reg[tt_pkg::NUM_BITS-1]};
        ge    = (trial >= {1'b0, den_reg});
        diff  = trial - {1'b0, den_reg};
    end

    // Control: step counter and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= tt_pkg::STEP_BITS'(tt_pkg::NUM_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == tt_pkg::STEP_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: product load, then shift quotient in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= {{tt_pkg::SCALE_BITS{1'b0}}, nm1} * tt_pkg::MS_PER_MIN_X100;
            rem_reg <= '0;
            den_reg <= dt;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[tt_pkg::NUM_BITS-2:0], ge};
            rem_reg <= ge ? diff[tt_pkg::TIME_BITS-1:0] : trial[tt_pkg::TIME_BITS-1:0];
        end
    end

    // Saturated result
    always_comb
    begin
        if (den_reg == '0)
            result = '0;
        else if (|quo_reg[tt_pkg::NUM_BITS-1:tt_pkg::TEMPO_BITS])
            result = '1;
        else
            result = quo_reg[tt_pkg::TEMPO_BITS-1:0];
    end

    assign done = done_reg;

endmodule

`default_nettype wire

// ----- rtl/tt_datapath.sv -----
// ============================================================================
// tt_datapath - run state, config registers and output word register
// Holds the run bookkeeping, forms divider operands and loads result words.
// ============================================================================
`default_nettype none

module tt_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire tt_pkg::cmd_t                      cmd,
    output tt_pkg::stat_t                          stat,
    // input word
    input  wire logic [1:0]                        kind,
    input  wire logic [31:0]                       time_ms,
    input  wire logic                              double_tap,
    // config
    input  wire logic                              cfg_we,
    input  wire logic                              cfg_index,
    input  wire logic [tt_pkg::APB_DATA_BITS-1:0]  cfg_wdata,
    output logic [tt_pkg::APB_DATA_BITS-1:0]       cfg_rdata,
    // divider
    output logic [tt_pkg::COUNT_BITS-1:0]          div_nm1,
    output logic [tt_pkg::TIME_BITS-1:0]           div_dt,
    input  wire logic                              div_done,
    input  wire logic [tt_pkg::TEMPO_BITS-1:0]     div_result,
    // output word
    input  wire logic                              out_stall,
    output logic                                   out_valid,
    output logic [1:0]                             item_type,
    output logic [23:0]                            bpm_x100,
    output logic [23:0]                            interval_bpm_x100,
    output logic [15:0]                            beat_count,
    output logic [31:0]                            elapsed_ms,
    output logic [15:0]                            group_length,
    output logic                                   running,
    output logic                                   last
);

    localparam logic [tt_pkg::COUNT_BITS-1:0] COUNT_MAX = '1;

    // Config registers
    logic [tt_pkg::DELAY_BITS-1:0] delay_reg;
    logic [tt_pkg::IVL_BITS-1:0]   ivl_reg;

    // Captured input word
    tt_pkg::kind_t                 kind_reg;
    logic [tt_pkg::TIME_BITS-1:0]  time_reg;
    logic                          dbl_reg;

    // Run state
    logic                          active_reg,      active_next;
    logic [tt_pkg::COUNT_BITS-1:0] beats_reg,       beats_next;
    logic [tt_pkg::TIME_BITS-1:0]  start_reg,       start_next;
    logic [tt_pkg::TIME_BITS-1:0]  last_tap_reg,    last_tap_next;
    logic [tt_pkg::TIME_BITS-1:0]  log_base_reg,    log_base_next;
    logic [tt_pkg::COUNT_BITS-1:0] mark_reg,        mark_next;
    logic                          prior_valid_reg, prior_valid_next;
    logic [tt_pkg::COUNT_BITS-1:0] prior_beats_reg, prior_beats_next;
    logic [tt_pkg::TIME_BITS-1:0]  prior_el_reg,    prior_el_next;
    logic [tt_pkg::TEMPO_BITS-1:0] tempo_reg,       tempo_next;
    logic                          keys_reg,        keys_next;

    // Output word register
    logic                          out_valid_reg;
    tt_pkg::item_type_t            type_reg;
    logic [tt_pkg::TEMPO_BITS-1:0] bpm_reg;
    logic [tt_pkg::TEMPO_BITS-1:0] ivl_bpm_reg;
    logic [tt_pkg::COUNT_BITS-1:0] beat_cnt_reg;
    logic [tt_pkg::TIME_BITS-1:0]  elapsed_reg;
    logic [tt_pkg::COUNT_BITS-1:0] group_reg;
    logic                          running_reg;
    logic                          last_reg;

    logic [tt_pkg::TIME_BITS-1:0]  elapsed;
    logic [tt_pkg::COUNT_BITS-1:0] group_len;
    logic [tt_pkg::COUNT_BITS-1:0] tap_base;
    logic [tt_pkg::COUNT_BITS-1:0] tap_one;
    logic [tt_pkg::COUNT_BITS-1:0] tap_two;
    logic [tt_pkg::COUNT_BITS-1:0] base_beats;
    logic [tt_pkg::TIME_BITS-1:0]  base_time;
    logic [tt_pkg::COUNT_BITS-1:0] n_beats;
    logic                          out_free;

    // Derived values
    always_comb
    begin
        elapsed   = last_tap_reg - start_reg;
        group_len = beats_reg - mark_reg;
        out_free  = !out_valid_reg || !out_stall;

        tap_base = active_reg ? beats_reg : '0;
        tap_one  = (tap_base == COUNT_MAX) ? COUNT_MAX : tap_base + 1'b1;
        if (dbl_reg)
            tap_two = (tap_one == COUNT_MAX) ? COUNT_MAX : tap_one + 1'b1;
        else
            tap_two = tap_one;
    end

    // Divider operands: overall tempo or interval since the prior log
    always_comb
    begin
        base_beats = '0;
        base_time  = '0;
        if (cmd.div_log && prior_valid_reg)
        begin
            base_beats = (prior_beats_reg == '0) ? '0 : prior_beats_reg - 1'b1;
            base_time  = prior_el_reg;
        end
        n_beats = (beats_reg >= base_beats) ? beats_reg - base_beats
                                            : tt_pkg::COUNT_BITS'(1);
        div_nm1 = (n_beats == '0) ? '0 : n_beats - 1'b1;
        div_dt  = elapsed - base_time;
    end

    // Status to controller
    always_comb
    begin
        stat.kind          = kind_reg;
        stat.run_active    = active_reg;
        stat.group_nonzero = (beats_reg > mark_reg);
        stat.keys_seen     = keys_reg;
        stat.log_due       = ((time_reg - log_base_reg) >=
                              tt_pkg::TIME_BITS'(ivl_reg));
        stat.stop_due      = (delay_reg != '0) &&
                             ((time_reg - last_tap_reg) >= tt_pkg::TIME_BITS'(delay_reg));
        stat.div_done      = div_done;
        stat.out_free      = out_free;
    end

    // Run state next values
    always_comb
    begin
        active_next      = active_reg;
        beats_next       = beats_reg;
        start_next       = start_reg;
        last_tap_next    = last_tap_reg;
        log_base_next    = log_base_reg;
        mark_next        = mark_reg;
        prior_valid_next = prior_valid_reg;
        prior_beats_next = prior_beats_reg;
        prior_el_next    = prior_el_reg;
        tempo_next       = tempo_reg;
        keys_next        = keys_reg;

        if (cmd.clear_run)
        begin
            active_next      = 1'b0;
            beats_next       = '0;
            start_next       = '0;
            last_tap_next    = '0;
            log_base_next    = '0;
            mark_next        = '0;
            prior_valid_next = 1'b0;
            prior_beats_next = '0;
            prior_el_next    = '0;
            tempo_next       = '0;
            keys_next        = 1'b0;
        end

        // tap: a stopped run restarts with clean state
        if (cmd.do_tap)
        begin
            if (!active_reg)
            begin
                active_next      = 1'b1;
                start_next       = time_reg;
                log_base_next    = time_reg;
                mark_next        = '0;
                prior_valid_next = 1'b0;
                prior_beats_next = '0;
                prior_el_next    = '0;
                tempo_next       = '0;
                keys_next        = 1'b0;
            end
            beats_next    = tap_two;
            last_tap_next = time_reg;
        end

        // group mark
        if (cmd.mark)
        begin
            mark_next = beats_reg;
            if (beats_reg > mark_reg)
                keys_next = 1'b1;
        end

        if (cmd.stop_run)
            active_next = 1'b0;

        if (cmd.tempo_load)
            tempo_next = div_result;

        if (cmd.log_update)
        begin
            prior_valid_next = 1'b1;
            prior_beats_next = beats_reg;
            prior_el_next    = elapsed;
        end

        if (cmd.base_adv)
            log_base_next = log_base_reg + tt_pkg::TIME_BITS'(ivl_reg);
    end

    // Run state and config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg       <= tt_pkg::AUTO_STOP_RESET;
            ivl_reg         <= tt_pkg::LOG_INTERVAL_RESET;
            active_reg      <= 1'b0;
            beats_reg       <= '0;
            start_reg       <= '0;
            last_tap_reg    <= '0;
            log_base_reg    <= '0;
            mark_reg        <= '0;
            prior_valid_reg <= 1'b0;
            prior_beats_reg <= '0;
            prior_el_reg    <= '0;
            tempo_reg       <= '0;
            keys_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == tt_pkg::REG_AUTO_STOP)
                delay_reg <= cfg_wdata[tt_pkg::DELAY_BITS-1:0];
            if (cfg_we && cfg_index == tt_pkg::REG_LOG_IVL)
                ivl_reg <= cfg_wdata[tt_pkg::IVL_BITS-1:0];

            active_reg      <= active_next;
            beats_reg       <= beats_next;
            start_reg       <= start_next;
            last_tap_reg    <= last_tap_next;
            log_base_reg    <= log_base_next;
            mark_reg        <= mark_next;
            prior_valid_reg <= prior_valid_next;
            prior_beats_reg <= prior_beats_next;
            prior_el_reg    <= prior_el_next;
            tempo_reg       <= tempo_next;
            keys_reg        <= keys_next;

            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Input capture and output word payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            kind_reg <= tt_pkg::kind_t'(kind);
            time_reg <= time_ms[tt_pkg::TIME_BITS-1:0];
            dbl_reg  <= double_tap;
        end
        if (cmd.emit)
        begin
            type_reg     <= cmd.emit_type;
            bpm_reg      <= tempo_reg;
            ivl_bpm_reg  <= (cmd.emit_type == tt_pkg::ITEM_LOG) ? div_result : '0;
            beat_cnt_reg <= beats_reg;
            elapsed_reg  <= elapsed;
            group_reg    <= (cmd.emit_type == tt_pkg::ITEM_GROUP) ? group_len : '0;
            running_reg  <= active_reg;
            last_reg     <= (cmd.emit_type == tt_pkg::ITEM_STATUS);
        end
    end

    // Config readback
    always_comb
    begin
        if (cfg_index == tt_pkg::REG_LOG_IVL)
            cfg_rdata = tt_pkg::APB_DATA_BITS'(ivl_reg);
        else
            cfg_rdata = tt_pkg::APB_DATA_BITS'(delay_reg);
    end

    assign out_valid         = out_valid_reg;
    assign item_type         = type_reg;
    assign bpm_x100          = bpm_reg;
    assign interval_bpm_x100 = ivl_bpm_reg;
    assign beat_count        = beat_cnt_reg;
    assign elapsed_ms        = elapsed_reg;
    assign group_length      = group_reg;
    assign running           = running_reg;
    assign last              = last_reg;

endmodule

`default_nettype wire

// ----- rtl/tt_ctrl.sv -----
// ============================================================================
// tt_ctrl - sequencing controller
// Steps one input word through group close, tap, log and auto-stop actions.
// ============================================================================
`default_nettype none

module tt_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire tt_pkg::stat_t  stat,
    output tt_pkg::cmd_t        cmd
);

    tt_pkg::state_t state_reg, state_next;
    logic           final_reg, final_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tt_pkg::ST_IDLE;
            final_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            final_reg <= final_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        final_next    = final_reg;
        cmd           = '0;
        cmd.emit_type = tt_pkg::ITEM_STATUS;
        in_stall      = 1'b1;

        case (state_reg)
            tt_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = tt_pkg::ST_DECODE;
                end
            end

            tt_pkg::ST_DECODE:
            begin
                final_next = 1'b0;
                case (stat.kind)
                    tt_pkg::KIND_TAP:
                        state_next = tt_pkg::ST_TAP;
                    tt_pkg::KIND_KEY:
                        state_next = stat.run_active ? tt_pkg::ST_GROUP : tt_pkg::ST_TAP;
                    tt_pkg::KIND_TICK:
                        state_next = stat.run_active ? tt_pkg::ST_TICK : tt_pkg::ST_STATUS;
                    tt_pkg::KIND_RESET:
                    begin
                        cmd.clear_run = 1'b1;
                        state_next    = tt_pkg::ST_STATUS;
                    end
                    default:
                        state_next = tt_pkg::ST_STATUS;
                endcase
            end

            // close the key group, word only if it has beats
            tt_pkg::ST_GROUP:
            begin
                if (!stat.group_nonzero || stat.out_free)
                begin
                    cmd.mark      = 1'b1;
                    cmd.emit      = stat.group_nonzero;
                    cmd.emit_type = tt_pkg::ITEM_GROUP;
                    state_next    = tt_pkg::ST_TAP;
                end
            end

            tt_pkg::ST_TAP:
            begin
                cmd.do_tap = 1'b1;
                state_next = tt_pkg::ST_TEMPO_DIV;
            end

            tt_pkg::ST_TEMPO_DIV:
            begin
                cmd.div_start = 1'b1;
                state_next    = tt_pkg::ST_TEMPO_WAIT;
            end

            tt_pkg::ST_TEMPO_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.tempo_load = 1'b1;
                    state_next     = tt_pkg::ST_STATUS;
                end
            end

            tt_pkg::ST_TICK:
                state_next = stat.log_due ? tt_pkg::ST_LOG_DIV : tt_pkg::ST_STOP_CHECK;

            tt_pkg::ST_LOG_DIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_log   = 1'b1;
                state_next    = tt_pkg::ST_LOG_WAIT;
            end

            tt_pkg::ST_LOG_WAIT:
            begin
                cmd.div_log = 1'b1;
                if (stat.div_done)
                    state_next = tt_pkg::ST_LOG_EMIT;
            end

            tt_pkg::ST_LOG_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit       = 1'b1;
                    cmd.emit_type  = tt_pkg::ITEM_LOG;
                    cmd.log_update = 1'b1;
                    if (final_reg)
                        state_next = tt_pkg::ST_STATUS;
                    else
                    begin
                        cmd.base_adv = 1'b1;
                        state_next   = tt_pkg::ST_STOP_CHECK;
                    end
                end
            end

            // idle long enough since the last tap: stop and log once more
            tt_pkg::ST_STOP_CHECK:
            begin
                if (!stat.stop_due)
                    state_next = tt_pkg::ST_STATUS;
                else if (stat.keys_seen)
                    state_next = tt_pkg::ST_STOP_GROUP;
                else
                begin
                    cmd.stop_run = 1'b1;
                    final_next   = 1'b1;
                    state_next   = tt_pkg::ST_LOG_DIV;
                end
            end

            tt_pkg::ST_STOP_GROUP:
            begin
                if (!stat.group_nonzero || stat.out_free)
                begin
                    cmd.mark      = 1'b1;
                    cmd.emit      = stat.group_nonzero;
                    cmd.emit_type = tt_pkg::ITEM_GROUP;
                    cmd.stop_run  = 1'b1;
                    final_next    = 1'b1;
                    state_next    = tt_pkg::ST_LOG_DIV;
                end
            end

            tt_pkg::ST_STATUS:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_type = tt_pkg::ITEM_STATUS;
                    state_next    = tt_pkg::ST_IDLE;
                end
            end

            default:
                state_next = tt_pkg::ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ----- sim/tap_tempo_bpm_meter_unit_tb.sv -----
// ============================================================================
// tap_tempo_bpm_meter_unit_tb - self-checking bench for the tap tempo meter
// Drives taps, key taps, ticks and resets through the valid/stall input
// channel and checks every result word against an in-bench tempo tracker.
// The tracker keeps its own run state and register copies and queues the
// result words each accepted input word should produce. Both channels idle
// and stall at random, and the APB registers are swept between phases.
// ============================================================================

// one result word, field for field as the block presents it
typedef struct packed {
    tt_pkg::item_type_t itype;
    logic [23:0]        tempo;
    logic [23:0]        span_tempo;
    logic [15:0]        beats;
    logic [31:0]        elapsed;
    logic [15:0]        group;
    logic               running;
    logic               last;
} tempo_word_t;

// Tempo tracker: mirrors the run state and holds the words still owed
class tempo_ledger;
    // register copies
    logic [15:0] stop_delay;
    logic [23:0] log_ivl;

    // run state
    bit          run_on;
    logic [15:0] beats;
    logic [31:0] run_start;
    logic [31:0] last_tap;
    logic [31:0] log_base;
    logic [15:0] mark_beats;
    bit          prior_ok;
    logic [15:0] prior_beats;
    logic [31:0] prior_elapsed;
    logic [23:0] tempo_now;
    bit          groups_seen;

    tempo_word_t owed_words[$];
    int          errors;
    int          n_in;
    int          n_out;
    int          n_log;
    int          n_group;
    int          n_stop;

    function new();
        stop_delay = tt_pkg::AUTO_STOP_RESET;
        log_ivl    = tt_pkg::LOG_INTERVAL_RESET;
        errors     = 0;
        n_in       = 0;
        n_out      = 0;
        n_log      = 0;
        n_group    = 0;
        n_stop     = 0;
        clear_run();
    endfunction

    function void clear_run();
        run_on        = 1'b0;
        beats         = '0;
        run_start     = '0;
        last_tap      = '0;
        log_base      = '0;
        mark_beats    = '0;
        prior_ok      = 1'b0;
        prior_beats   = '0;
        prior_elapsed = '0;
        tempo_now     = '0;
        groups_seen   = 1'b0;
    endfunction

    function void set_reg(logic idx, logic [31:0] data);
        if (idx == tt_pkg::REG_LOG_IVL)
            log_ivl = data[23:0];
        else
            stop_delay = data[15:0];
    endfunction

    // floor((n-1) * 6000000 / dt), n at least 1, zero for dt zero, saturated
    function logic [23:0] tempo_of(logic [31:0] n_beats, logic [31:0] dt);
        logic [63:0] n;
        logic [63:0] q;
        n = (n_beats < 1) ? 64'd1 : {32'd0, n_beats};
        if (dt == 0)
            return '0;
        q = ((n - 1) * 64'(tt_pkg::MS_PER_MIN_X100)) / {32'd0, dt};
        return (q > 64'hFF_FFFF) ? 24'hFF_FFFF : q[23:0];
    endfunction

    function void owe(tt_pkg::item_type_t ty, logic [23:0] span, logic [15:0] grp,
                      bit fin);
        tempo_word_t w;
        w.itype      = ty;
        w.tempo      = tempo_now;
        w.span_tempo = span;
        w.beats      = beats;
        w.elapsed    = last_tap - run_start;
        w.group      = grp;
        w.running    = run_on;
        w.last       = fin;
        owed_words.push_back(w);
    endfunction

    // log record: tempo since the previous log of this run
    function void log_record();
        logic [31:0] el;
        logic [31:0] base_time;
        logic [31:0] dt;
        logic [15:0] base_beats;
        logic [31:0] n;
        el         = last_tap - run_start;
        base_beats = '0;
        base_time  = '0;
        if (prior_ok) begin
            base_beats = (prior_beats > 0) ? prior_beats - 16'd1 : 16'd0;
            base_time  = prior_elapsed;
        end
        n  = (beats >= base_beats) ? 32'(beats - base_beats) : 32'd1;
        dt = el - base_time;
        owe(tt_pkg::ITEM_LOG, tempo_of(n, dt), '0, 1'b0);
        prior_ok      = 1'b1;
        prior_beats   = beats;
        prior_elapsed = el;
        n_log++;
    endfunction

    function void close_group();
        logic [15:0] g;
        g = beats - mark_beats;
        if (beats >= mark_beats && g > 0) begin
            owe(tt_pkg::ITEM_GROUP, '0, g, 1'b0);
            groups_seen = 1'b1;
            n_group++;
        end
        mark_beats = beats;
    endfunction

    function void tap(logic [31:0] t, bit dbl);
        if (!run_on) begin
            clear_run();
            run_on    = 1'b1;
            run_start = t;
            log_base  = t;
        end
        if (beats != 16'hFFFF)
            beats++;
        if (dbl && beats != 16'hFFFF)
            beats++;
        last_tap  = t;
        tempo_now = tempo_of(32'(beats), last_tap - run_start);
    endfunction

    // accepted input word: advance the state and queue its results
    function void note_word(tt_pkg::kind_t k, logic [31:0] t, bit dbl);
        logic [31:0] since_base;
        logic [31:0] since_tap;
        n_in++;
        case (k)
            tt_pkg::KIND_TAP: tap(t, dbl);
            tt_pkg::KIND_KEY:
            begin
                if (run_on)
                    close_group();
                tap(t, dbl);
            end
            tt_pkg::KIND_TICK:
            begin
                if (run_on) begin
                    since_base = t - log_base;
                    if (since_base >= 32'(log_ivl)) begin
                        log_record();
                        log_base = log_base + 32'(log_ivl);
                    end
                    since_tap = t - last_tap;
                    if (stop_delay != 0 && since_tap >= 32'(stop_delay)) begin
                        if (groups_seen)
                            close_group();
                        run_on = 1'b0;
                        log_record();
                        n_stop++;
                    end
                end
            end
            default: clear_run();
        endcase
        owe(tt_pkg::ITEM_STATUS, '0, '0, 1'b1);
    endfunction

    function string show(tempo_word_t w);
        return $sformatf("type %0d tempo %0d span %0d beats %0d el %0d grp %0d run %b last %b",
                         w.itype, w.tempo, w.span_tempo, w.beats, w.elapsed, w.group,
                         w.running, w.last);
    endfunction

    task report(string msg);
        errors++;
        $display("MISMATCH %s", msg);
    endtask

    // accepted result word: compare with the oldest owed word
    task check_word(tempo_word_t got);
        tempo_word_t want;
        string       bad;
        n_out++;
        if (owed_words.size() == 0) begin
            report({"result word with nothing owed: ", show(got)});
            return;
        end
        want = owed_words.pop_front();
        bad  = "";
        if (got.itype !== want.itype)           bad = {bad, " item_type"};
        if (got.tempo !== want.tempo)           bad = {bad, " bpm_x100"};
        if (got.span_tempo !== want.span_tempo) bad = {bad, " interval_bpm_x100"};
        if (got.beats !== want.beats)           bad = {bad, " beat_count"};
        if (got.elapsed !== want.elapsed)       bad = {bad, " elapsed_ms"};
        if (got.group !== want.group)           bad = {bad, " group_length"};
        if (got.running !== want.running)       bad = {bad, " running"};
        if (got.last !== want.last)             bad = {bad, " last"};
        if (bad != "")
            report($sformatf("result %0d%s: got %s / want %s", n_out, bad, show(got),
                             show(want)));
    endtask
endclass

module tap_tempo_bpm_meter_unit_tb;

    localparam int QUIET_LIMIT = 1000;
    localparam logic [tt_pkg::APB_ADDR_BITS-1:0] ADDR_STOP = {tt_pkg::REG_AUTO_STOP, 2'b00};
    localparam logic [tt_pkg::APB_ADDR_BITS-1:0] ADDR_IVL  = {tt_pkg::REG_LOG_IVL, 2'b00};

    logic                             clk;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_stall;
    logic [1:0]                       kind;
    logic [31:0]                      time_ms;
    logic                             double_tap;
    logic                             out_valid;
    logic                             out_stall;
    logic [1:0]                       item_type;
    logic [23:0]                      bpm_x100;
    logic [23:0]                      interval_bpm_x100;
    logic [15:0]                      beat_count;
    logic [31:0]                      elapsed_ms;
    logic [15:0]                      group_length;
    logic                             running;
    logic                             last;
    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [tt_pkg::APB_ADDR_BITS-1:0] paddr;
    logic [tt_pkg::APB_DATA_BITS-1:0] pwdata;
    logic [tt_pkg::APB_DATA_BITS-1:0] prdata;
    logic                             pready;

    tempo_ledger ledger;
    tempo_word_t seen;
    bit          calm;
    int          hold;
    int          n_cfg;
    logic [31:0] clock_ms;

    tap_tempo_bpm_meter_unit dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .kind              (kind),
        .time_ms           (time_ms),
        .double_tap        (double_tap),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .item_type         (item_type),
        .bpm_x100          (bpm_x100),
        .interval_bpm_x100 (interval_bpm_x100),
        .beat_count        (beat_count),
        .elapsed_ms        (elapsed_ms),
        .group_length      (group_length),
        .running           (running),
        .last              (last),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // idle / stall length for one word; zero during calm stretches
    function automatic int pick_gap();
        if (calm)
            return 0;
        return $urandom_range(0, 6);
    endfunction

    // result side: check each accepted word, then stall a random while
    initial
    begin
        hold      = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) begin
                seen.itype      = tt_pkg::item_type_t'(item_type);
                seen.tempo      = bpm_x100;
                seen.span_tempo = interval_bpm_x100;
                seen.beats      = beat_count;
                seen.elapsed    = elapsed_ms;
                seen.group      = group_length;
                seen.running    = running;
                seen.last       = last;
                ledger.check_word(seen);
                hold = pick_gap();
            end
            @(negedge clk);
            if (hold > 0) begin
                out_stall = 1'b1;
                hold--;
            end
            else
                out_stall = 1'b0;
        end
    end

    // watchdog: ends the run after too long without any handshake
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if (!rst_n || psel || (in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    // one APB transfer, setup then access; starts and ends at a falling edge
    task apb_cycle(bit wr, logic [tt_pkg::APB_ADDR_BITS-1:0] addr, logic [31:0] wdata,
                   output logic [31:0] rdata);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = addr;
        pwdata  = wdata;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        if (wr)
            ledger.set_reg(addr[2], wdata);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task check_reg(logic [tt_pkg::APB_ADDR_BITS-1:0] addr);
        logic [31:0] got;
        logic [31:0] want;
        apb_cycle(1'b0, addr, '0, got);
        want = (addr[2] == tt_pkg::REG_LOG_IVL) ? 32'(ledger.log_ivl)
                                                : 32'(ledger.stop_delay);
        if (got !== want)
            ledger.report($sformatf("register at %0d reads %h, want %h", addr, got, want));
    endtask

    task write_reg(logic [tt_pkg::APB_ADDR_BITS-1:0] addr, logic [31:0] data);
        logic [31:0] unused;
        apb_cycle(1'b1, addr, data, unused);
        check_reg(addr);
        n_cfg++;
    endtask

    // input side: optional idle gap, then hold the word until accepted
    task send_word(tt_pkg::kind_t k, logic [31:0] t, bit dbl);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        kind       = k;
        time_ms    = t;
        double_tap = dbl;
        in_valid   = 1'b1;
        do @(posedge clk); while (in_stall);
        ledger.note_word(k, t, dbl);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // hold off input until every owed word has come back
    task drain();
        in_valid = 1'b0;
        while (ledger.owed_words.size() != 0)
            @(posedge clk);
        @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // random runs: mostly taps and ticks on a rising clock, some resets
    // and big time jumps that force logs, auto stops and wraparound
    task run_random(int count);
        int          r;
        logic [31:0] step;
        clock_ms = $urandom;
        repeat (count) begin
            r    = $urandom_range(0, 99);
            step = ($urandom_range(0, 9) == 0) ? 32'd0 : 32'($urandom_range(40, 900));
            if (r < 3)
                send_word(tt_pkg::KIND_RESET, $urandom, 1'($urandom_range(0, 1)));
            else if (r < 8) begin
                clock_ms += $urandom;
                send_word(tt_pkg::KIND_TICK, clock_ms, 1'($urandom_range(0, 1)));
            end
            else if (r < 40) begin
                clock_ms += step;
                send_word(tt_pkg::KIND_TAP, clock_ms, $urandom_range(0, 3) == 0);
            end
            else if (r < 55) begin
                clock_ms += step;
                send_word(tt_pkg::KIND_KEY, clock_ms, $urandom_range(0, 3) == 0);
            end
            else begin
                clock_ms += 32'($urandom_range(20, 1200));
                send_word(tt_pkg::KIND_TICK, clock_ms, 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // main sequence
    initial begin
        ledger     = new();
        calm       = 1'b0;
        n_cfg      = 0;
        clock_ms   = '0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        kind       = tt_pkg::KIND_TAP;
        time_ms    = '0;
        double_tap = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset values of both registers
        check_reg(ADDR_STOP);
        check_reg(ADDR_IVL);

        // directed: default registers, full run ending in a four-word tick
        send_word(tt_pkg::KIND_TICK, 32'd0, 1'b0);       // tick while stopped
        send_word(tt_pkg::KIND_KEY, 32'd1000, 1'b0);     // key tap starts a run, no group
        send_word(tt_pkg::KIND_TAP, 32'd1500, 1'b1);
        send_word(tt_pkg::KIND_KEY, 32'd2000, 1'b0);     // closes first group
        send_word(tt_pkg::KIND_TAP, 32'd2000, 1'b0);
        send_word(tt_pkg::KIND_TICK, 32'd3999, 1'b0);    // one short of auto stop
        send_word(tt_pkg::KIND_TICK, 32'd17000, 1'b1);   // log, group, final log, status
        send_word(tt_pkg::KIND_TICK, 32'd18000, 1'b0);
        // zero elapsed, saturated tempo, time wrap, resets
        send_word(tt_pkg::KIND_TAP, 32'hFFFF_FFF0, 1'b0);
        send_word(tt_pkg::KIND_TAP, 32'hFFFF_FFF0, 1'b1);
        send_word(tt_pkg::KIND_TAP, 32'hFFFF_FFF1, 1'b1);
        send_word(tt_pkg::KIND_KEY, 32'h0000_0010, 1'b0);
        send_word(tt_pkg::KIND_RESET, 32'hFFFF_FFFF, 1'b1);
        send_word(tt_pkg::KIND_TICK, 32'hFFFF_FFFF, 1'b0);
        send_word(tt_pkg::KIND_RESET, 32'd0, 1'b0);
        drain();

        // zero interval logs every tick, zero delay never stops
        write_reg(ADDR_STOP, 32'hFFFF_0000);
        write_reg(ADDR_IVL, 32'hFF00_0000);
        send_word(tt_pkg::KIND_TAP, 32'd100, 1'b0);
        send_word(tt_pkg::KIND_TICK, 32'd100, 1'b0);
        send_word(tt_pkg::KIND_TAP, 32'd700, 1'b1);
        send_word(tt_pkg::KIND_TICK, 32'h8000_0000, 1'b0);
        send_word(tt_pkg::KIND_TICK, 32'h8000_0001, 1'b1);
        send_word(tt_pkg::KIND_RESET, 32'h5555_5555, 1'b0);
        drain();

        // largest delay and interval, log lands exactly on the boundary
        write_reg(ADDR_STOP, 32'h0000_FFFF);
        write_reg(ADDR_IVL, 32'h00FF_FFFF);
        send_word(tt_pkg::KIND_TAP, 32'hAAAA_AAAA, 1'b0);
        send_word(tt_pkg::KIND_TAP, 32'hAAAB_AAAA, 1'b1);
        send_word(tt_pkg::KIND_TICK, 32'hAAAA_AAAA + 32'h00FF_FFFF, 1'b0);
        drain();

        // random phases over several register settings
        write_reg(ADDR_STOP, {16'($urandom), 16'd1500});
        write_reg(ADDR_IVL, {8'($urandom), 24'd3000});
        run_random(50);
        drain();

        calm = 1'b1;
        write_reg(ADDR_STOP, {16'($urandom), 16'd0});
        write_reg(ADDR_IVL, {8'($urandom), 24'($urandom_range(500, 4000))});
        run_random(45);
        drain();
        calm = 1'b0;

        write_reg(ADDR_STOP, {16'($urandom), 16'hFFFF});
        write_reg(ADDR_IVL, {8'($urandom), 24'hFF_FFFF});
        run_random(45);
        drain();

        write_reg(ADDR_STOP, {16'($urandom), 16'($urandom_range(1, 5000))});
        write_reg(ADDR_IVL, {8'($urandom), 24'($urandom_range(0, 2500))});
        run_random(50);
        drain();

        // let any stray word show up before closing
        repeat (40) @(posedge clk);
        if (ledger.owed_words.size() != 0)
            ledger.report($sformatf("%0d result words never arrived",
                                    ledger.owed_words.size()));

        $display("covered %0d input words (taps, key taps, ticks, resets) over %0d writes",
                 ledger.n_in, n_cfg);
        $display("checked %0d result words: %0d log records, %0d group lengths, %0d stops",
                 ledger.n_out, ledger.n_log, ledger.n_group, ledger.n_stop);
        if (ledger.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/tt_pkg.sv
rtl/tt_div.sv
rtl/tt_datapath.sv
rtl/tt_ctrl.sv
rtl/tap_tempo_bpm_meter_unit.sv
sim/tap_tempo_bpm_meter_unit_tb.sv
